@@ sv/iag_pkg.sv @@
// Package for the indexed address generator: payload structs, config struct,
// postbyte mode codes and small decode helpers. No dependencies.
package iag_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_STEP_ONE    = 3'd0;
	localparam logic [2:0] CFG_STEP_TWO    = 3'd1;
	localparam logic [2:0] CFG_D_OFFSET    = 3'd2;
	localparam logic [2:0] CFG_WORD_OFFSET = 3'd3;
	localparam logic [2:0] CFG_PC_WORD     = 3'd4;

	// Postbyte mode field (bits 4..0 when bit 7 is set)
	localparam logic [4:0] MODE_POST_INC1    = 5'd0;
	localparam logic [4:0] MODE_POST_INC2    = 5'd1;
	localparam logic [4:0] MODE_PRE_DEC1     = 5'd2;
	localparam logic [4:0] MODE_PRE_DEC2     = 5'd3;
	localparam logic [4:0] MODE_W_DIRECT     = 5'd15;
	localparam logic [4:0] MODE_W_INDIRECT   = 5'd16;
	localparam logic [4:0] MODE_IND_INC2     = 5'd17;
	localparam logic [4:0] MODE_ILLEGAL      = 5'd18;
	localparam logic [4:0] MODE_IND_DEC2     = 5'd19;
	localparam logic [4:0] MODE_EXT_INDIRECT = 5'd31;

	// Low nibble of offset-style modes
	localparam logic [3:0] LOW_NO_OFFSET = 4'd4;
	localparam logic [3:0] LOW_ACC_B     = 4'd5;
	localparam logic [3:0] LOW_ACC_A     = 4'd6;
	localparam logic [3:0] LOW_ACC_E     = 4'd7;
	localparam logic [3:0] LOW_OFF8      = 4'd8;
	localparam logic [3:0] LOW_OFF16     = 4'd9;
	localparam logic [3:0] LOW_ACC_F     = 4'd10;
	localparam logic [3:0] LOW_ACC_D     = 4'd11;
	localparam logic [3:0] LOW_PC_OFF8   = 4'd12;
	localparam logic [3:0] LOW_PC_OFF16  = 4'd13;
	localparam logic [3:0] LOW_ACC_W     = 4'd14;

	// W-mode sub-select (postbyte bits 6..5)
	localparam logic [1:0] WSEL_PLAIN  = 2'd0;
	localparam logic [1:0] WSEL_OFF16  = 2'd1;
	localparam logic [1:0] WSEL_INC2   = 2'd2;

	typedef struct packed {
		logic [7:0]  postbyte;
		logic [15:0] index_value;
		logic [7:0]  acc_a;
		logic [7:0]  acc_b;
		logic [7:0]  acc_e;
		logic [7:0]  acc_f;
		logic [15:0] w_value;
		logic [15:0] pc_value;
		logic [15:0] operand_word;
	} iag_in_t;

	typedef struct packed {
		logic [15:0] address;
		logic        indirect;
		logic [1:0]  index_select;
		logic [15:0] new_index;
		logic        index_write;
		logic [15:0] new_w;
		logic        w_write;
		logic [1:0]  pc_advance;
		logic [3:0]  cycles_added;
		logic        illegal;
	} iag_out_t;

	typedef struct packed {
		logic [3:0] step_one;
		logic [3:0] step_two;
		logic [3:0] d_offset;
		logic [3:0] word_offset;
		logic [3:0] pc_word;
	} iag_cfg_t;

	function automatic logic [15:0] sext8(input logic [7:0] v);
		return {{8{v[7]}}, v};
	endfunction

	// Added cycles of the indirect offset modes, by low nibble
	function automatic logic [3:0] ind_cycles(input logic [3:0] low);
		logic [3:0] c;
		case (low)
			LOW_NO_OFFSET: c = 4'd3;
			LOW_OFF16:     c = 4'd7;
			LOW_ACC_D:     c = 4'd7;
			LOW_PC_OFF16:  c = 4'd8;
			LOW_ACC_W:     c = 4'd7;
			default:       c = 4'd4;
		endcase
		return c;
	endfunction

endpackage

@@ sv/iag_cfg_regs.sv @@
// Configuration register bank for the indexed address generator.
// Depends on iag_pkg.
module iag_cfg_regs
	import iag_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [3:0] cfg_data,
	output iag_cfg_t   cfg
);

	iag_cfg_t cfg_q;

	// Indexed write; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_one    <= 4'd2;
			cfg_q.step_two    <= 4'd3;
			cfg_q.d_offset    <= 4'd4;
			cfg_q.word_offset <= 4'd4;
			cfg_q.pc_word     <= 4'd5;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_STEP_ONE:    cfg_q.step_one    <= cfg_data;
				CFG_STEP_TWO:    cfg_q.step_two    <= cfg_data;
				CFG_D_OFFSET:    cfg_q.d_offset    <= cfg_data;
				CFG_WORD_OFFSET: cfg_q.word_offset <= cfg_data;
				CFG_PC_WORD:     cfg_q.pc_word     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/iag_calc.sv @@
// Combinational postbyte decode and effective address computation.
// Depends on iag_pkg.
module iag_calc
	import iag_pkg::*;
(
	input  iag_in_t  din,
	input  iag_cfg_t cfg,
	output iag_out_t dout
);

	logic [15:0] ix;
	logic [15:0] w;
	logic [4:0]  mode;
	logic [3:0]  low;
	logic [15:0] base_addr;
	logic [1:0]  base_adv;

	assign ix   = din.index_value;
	assign w    = din.w_value;
	assign mode = din.postbyte[4:0];
	assign low  = mode[3:0];

	// Offset-style address shared by direct and indirect forms
	always_comb begin
		base_adv = 2'd0;
		case (low)
			LOW_ACC_B:    base_addr = ix + sext8(din.acc_b);
			LOW_ACC_A:    base_addr = ix + sext8(din.acc_a);
			LOW_ACC_E:    base_addr = ix + sext8(din.acc_e);
			LOW_ACC_F:    base_addr = ix + sext8(din.acc_f);
			LOW_ACC_D:    base_addr = ix + {din.acc_a, din.acc_b};
			LOW_ACC_W:    base_addr = ix + w;
			LOW_OFF8: begin
				base_addr = ix + sext8(din.operand_word[15:8]);
				base_adv  = 2'd1;
			end
			LOW_OFF16: begin
				base_addr = ix + din.operand_word;
				base_adv  = 2'd2;
			end
			LOW_PC_OFF8: begin
				base_addr = din.pc_value + sext8(din.operand_word[15:8]) + 16'd1;
				base_adv  = 2'd1;
			end
			LOW_PC_OFF16: begin
				base_addr = din.pc_value + din.operand_word + 16'd2;
				base_adv  = 2'd2;
			end
			default:      base_addr = ix;
		endcase
	end

	// Mode decode
	always_comb begin
		dout              = '0;
		dout.index_select = din.postbyte[6:5];
		dout.new_index    = ix;
		dout.new_w        = w;
		if (!din.postbyte[7]) begin
			// five-bit signed offset
			dout.address      = ix + {{11{din.postbyte[4]}}, din.postbyte[4:0]};
			dout.cycles_added = 4'd1;
		end else begin
			case (mode)
				MODE_POST_INC1: begin
					dout.address      = ix;
					dout.new_index    = ix + 16'd1;
					dout.index_write  = 1'b1;
					dout.cycles_added = cfg.step_one;
				end
				MODE_POST_INC2: begin
					dout.address      = ix;
					dout.new_index    = ix + 16'd2;
					dout.index_write  = 1'b1;
					dout.cycles_added = cfg.step_two;
				end
				MODE_PRE_DEC1: begin
					dout.address      = ix - 16'd1;
					dout.new_index    = ix - 16'd1;
					dout.index_write  = 1'b1;
					dout.cycles_added = cfg.step_one;
				end
				MODE_PRE_DEC2: begin
					dout.address      = ix - 16'd2;
					dout.new_index    = ix - 16'd2;
					dout.index_write  = 1'b1;
					dout.cycles_added = cfg.step_two;
				end
				MODE_W_DIRECT, MODE_W_INDIRECT: begin
					dout.indirect = (mode == MODE_W_INDIRECT);
					case (din.postbyte[6:5])
						WSEL_PLAIN: begin
							dout.address      = w;
							dout.cycles_added = dout.indirect ? 4'd3 : 4'd0;
						end
						WSEL_OFF16: begin
							dout.address      = w + din.operand_word;
							dout.pc_advance   = 2'd2;
							dout.cycles_added = dout.indirect ? 4'd5 : 4'd2;
						end
						WSEL_INC2: begin
							dout.address      = w;
							dout.new_w        = w + 16'd2;
							dout.w_write      = 1'b1;
							dout.cycles_added = dout.indirect ? 4'd4 : 4'd1;
						end
						default: begin
							dout.address      = w - 16'd2;
							dout.new_w        = w - 16'd2;
							dout.w_write      = 1'b1;
							dout.cycles_added = dout.indirect ? 4'd4 : 4'd1;
						end
					endcase
				end
				MODE_IND_INC2: begin
					dout.address      = ix;
					dout.new_index    = ix + 16'd2;
					dout.index_write  = 1'b1;
					dout.indirect     = 1'b1;
					dout.cycles_added = 4'd6;
				end
				MODE_ILLEGAL: begin
					dout.illegal      = 1'b1;
					dout.cycles_added = 4'd6;
				end
				MODE_IND_DEC2: begin
					dout.address      = ix - 16'd2;
					dout.new_index    = ix - 16'd2;
					dout.index_write  = 1'b1;
					dout.indirect     = 1'b1;
					dout.cycles_added = 4'd6;
				end
				MODE_EXT_INDIRECT: begin
					dout.address      = din.operand_word;
					dout.pc_advance   = 2'd2;
					dout.indirect     = 1'b1;
					dout.cycles_added = 4'd8;
				end
				default: begin
					// offset modes; bit 4 selects the indirect form
					dout.address    = base_addr;
					dout.pc_advance = base_adv;
					if (mode[4]) begin
						dout.indirect     = 1'b1;
						dout.cycles_added = ind_cycles(low);
					end else begin
						case (low)
							LOW_NO_OFFSET: dout.cycles_added = 4'd0;
							LOW_OFF16:     dout.cycles_added = cfg.word_offset;
							LOW_ACC_D:     dout.cycles_added = cfg.d_offset;
							LOW_PC_OFF16:  dout.cycles_added = cfg.pc_word;
							LOW_ACC_W:     dout.cycles_added = 4'd4;
							default:       dout.cycles_added = 4'd1;
						endcase
					end
				end
			endcase
		end
	end

endmodule

@@ sv/indexed_address_generator_core.sv @@
// Indexed address generator: input register, decode logic, result register.
// Each item passes the input register and then the result register before out_valid rises; out_stall can hold it.
// Throughput: one item per cycle while out_stall is low; a full pipeline holds two items under stall.
// Reset: arst_n clears both stage valids and restores config defaults.
// Depends on iag_pkg, iag_cfg_regs, iag_calc.
module indexed_address_generator_core
	import iag_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  iag_in_t    in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output iag_out_t   out_data,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [3:0] cfg_data
);

	iag_cfg_t cfg;
	iag_in_t  data_s1;
	logic     valid_s1;
	iag_out_t result;
	iag_out_t data_s2;
	logic     valid_s2;
	logic     adv_s1;
	logic     adv_s2;

	iag_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage load enables
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			data_s1 <= in_data;
		end
	end

	iag_calc u_calc (
		.din  (data_s1),
		.cfg  (cfg),
		.dout (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			data_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for indexed_address_generator_core: directed table plus random postbytes, each result checked against
// a hand-typed expectation or an in-bench effective address predictor. Depends on iag_pkg.
module tb;
	import iag_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int NUM_PHASES    = 6;
	localparam int PHASE_ITEMS   = 200;
	localparam int DRAIN_CYCLES  = 8;
	// Added cycles of the indirect offset modes, low nibble 4 in the low slot
	localparam logic [43:0] IND_CYC = {4'd7, 4'd8, 4'd4, 4'd7, 4'd4, 4'd7,
		4'd4, 4'd4, 4'd4, 4'd4, 4'd3};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	iag_in_t    in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	iag_out_t   out_data;
	logic       cfg_wr_en = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;

	// Hand-typed expectation that rides along with the current transfer
	logic       row_typed = 1'b0;
	iag_out_t   row_ea = '0;

	iag_cfg_t   cycle_cfg;
	iag_out_t   expected_ea [$];
	iag_in_t    dir_stim [$];
	bit         dir_typed [$];
	iag_out_t   dir_ea [$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	bit         rx_fast = 1'b0;

	indexed_address_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Effective address, write-backs and cycle count for one postbyte
	function automatic iag_out_t calc_effective_address(input iag_in_t x, input iag_cfg_t c);
		iag_out_t    r;
		logic [4:0]  mode;
		logic [3:0]  low;
		logic [15:0] ix;
		logic [15:0] w;
		logic [7:0]  off8;
		int          k;
		r = '0;
		ix = x.index_value;
		w = x.w_value;
		mode = x.postbyte[4:0];
		low = mode[3:0];
		off8 = x.operand_word[15:8];
		r.index_select = x.postbyte[6:5];
		r.new_index = ix;
		r.new_w = w;
		if (!x.postbyte[7]) begin
			// five-bit signed offset
			r.address = ix + {{11{mode[4]}}, mode};
			r.cycles_added = 4'd1;
		end else begin
			case (mode)
				MODE_POST_INC1: begin
					r.address = ix;
					r.new_index = ix + 16'd1;
					r.index_write = 1'b1;
					r.cycles_added = c.step_one;
				end
				MODE_POST_INC2: begin
					r.address = ix;
					r.new_index = ix + 16'd2;
					r.index_write = 1'b1;
					r.cycles_added = c.step_two;
				end
				MODE_PRE_DEC1: begin
					r.new_index = ix - 16'd1;
					r.address = r.new_index;
					r.index_write = 1'b1;
					r.cycles_added = c.step_one;
				end
				MODE_PRE_DEC2: begin
					r.new_index = ix - 16'd2;
					r.address = r.new_index;
					r.index_write = 1'b1;
					r.cycles_added = c.step_two;
				end
				MODE_W_DIRECT, MODE_W_INDIRECT: begin
					// register slot picks the W flavor; index register untouched
					r.indirect = (mode == MODE_W_INDIRECT);
					case (x.postbyte[6:5])
						WSEL_PLAIN: begin
							r.address = w;
							r.cycles_added = r.indirect ? 4'd3 : 4'd0;
						end
						WSEL_OFF16: begin
							r.address = w + x.operand_word;
							r.pc_advance = 2'd2;
							r.cycles_added = r.indirect ? 4'd5 : 4'd2;
						end
						WSEL_INC2: begin
							r.address = w;
							r.new_w = w + 16'd2;
							r.w_write = 1'b1;
							r.cycles_added = r.indirect ? 4'd4 : 4'd1;
						end
						default: begin
							r.new_w = w - 16'd2;
							r.address = r.new_w;
							r.w_write = 1'b1;
							r.cycles_added = r.indirect ? 4'd4 : 4'd1;
						end
					endcase
				end
				MODE_IND_INC2: begin
					r.address = ix;
					r.new_index = ix + 16'd2;
					r.index_write = 1'b1;
					r.indirect = 1'b1;
					r.cycles_added = 4'd6;
				end
				MODE_ILLEGAL: begin
					r.address = '0;
					r.illegal = 1'b1;
					r.cycles_added = 4'd6;
				end
				MODE_IND_DEC2: begin
					r.new_index = ix - 16'd2;
					r.address = r.new_index;
					r.index_write = 1'b1;
					r.indirect = 1'b1;
					r.cycles_added = 4'd6;
				end
				MODE_EXT_INDIRECT: begin
					r.address = x.operand_word;
					r.pc_advance = 2'd2;
					r.indirect = 1'b1;
					r.cycles_added = 4'd8;
				end
				default: begin
					// offset modes, bit 4 marks the indirect variant
					r.indirect = mode[4];
					case (low)
						LOW_ACC_B:    r.address = ix + {{8{x.acc_b[7]}}, x.acc_b};
						LOW_ACC_A:    r.address = ix + {{8{x.acc_a[7]}}, x.acc_a};
						LOW_ACC_E:    r.address = ix + {{8{x.acc_e[7]}}, x.acc_e};
						LOW_ACC_F:    r.address = ix + {{8{x.acc_f[7]}}, x.acc_f};
						LOW_ACC_D:    r.address = ix + {x.acc_a, x.acc_b};
						LOW_ACC_W:    r.address = ix + w;
						LOW_OFF8: begin
							r.address = ix + {{8{off8[7]}}, off8};
							r.pc_advance = 2'd1;
						end
						LOW_OFF16: begin
							r.address = ix + x.operand_word;
							r.pc_advance = 2'd2;
						end
						LOW_PC_OFF8: begin
							r.address = x.pc_value + {{8{off8[7]}}, off8} + 16'd1;
							r.pc_advance = 2'd1;
						end
						LOW_PC_OFF16: begin
							r.address = x.pc_value + x.operand_word + 16'd2;
							r.pc_advance = 2'd2;
						end
						default:      r.address = ix;
					endcase
					if (r.indirect) begin
						k = low - 4;
						r.cycles_added = IND_CYC[k*4 +: 4];
					end else begin
						case (low)
							LOW_NO_OFFSET: r.cycles_added = 4'd0;
							LOW_OFF16:     r.cycles_added = c.word_offset;
							LOW_ACC_D:     r.cycles_added = c.d_offset;
							LOW_PC_OFF16:  r.cycles_added = c.pc_word;
							LOW_ACC_W:     r.cycles_added = 4'd4;
							default:       r.cycles_added = 4'd1;
						endcase
					end
				end
			endcase
		end
		return r;
	endfunction

	function automatic iag_in_t mk_in(input logic [7:0] pb, input logic [15:0] ix,
		input logic [7:0] a, input logic [7:0] b, input logic [7:0] e, input logic [7:0] f,
		input logic [15:0] w, input logic [15:0] pc, input logic [15:0] opw);
		iag_in_t s;
		s.postbyte = pb;
		s.index_value = ix;
		s.acc_a = a;
		s.acc_b = b;
		s.acc_e = e;
		s.acc_f = f;
		s.w_value = w;
		s.pc_value = pc;
		s.operand_word = opw;
		return s;
	endfunction

	function automatic iag_out_t mk_out(input logic [15:0] addr, input logic ind,
		input logic [1:0] rsel, input logic [15:0] nidx, input logic iw,
		input logic [15:0] nw, input logic ww, input logic [1:0] adv,
		input logic [3:0] cyc, input logic ill);
		iag_out_t r;
		r.address = addr;
		r.indirect = ind;
		r.index_select = rsel;
		r.new_index = nidx;
		r.index_write = iw;
		r.new_w = nw;
		r.w_write = ww;
		r.pc_advance = adv;
		r.cycles_added = cyc;
		r.illegal = ill;
		return r;
	endfunction

	// Random word with a bias toward the corners
	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h8000;
			3:       return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_row(input iag_in_t s, input bit typed, input iag_out_t e);
		dir_stim.push_back(s);
		dir_typed.push_back(typed);
		dir_ea.push_back(e);
	endtask

	// One input transfer, after a drawn gap unless fast
	task automatic send_item(input iag_in_t s, input bit typed, input iag_out_t e,
		input bit fast);
		int gap;
		gap = fast ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		row_typed <= typed;
		row_ea <= e;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// Hold off input until every pending result has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_ea.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input iag_cfg_t c);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_STEP_ONE;
		cfg_data <= c.step_one;
		@(posedge clk);
		cfg_index <= CFG_STEP_TWO;
		cfg_data <= c.step_two;
		@(posedge clk);
		cfg_index <= CFG_D_OFFSET;
		cfg_data <= c.d_offset;
		@(posedge clk);
		cfg_index <= CFG_WORD_OFFSET;
		cfg_data <= c.word_offset;
		@(posedge clk);
		cfg_index <= CFG_PC_WORD;
		cfg_data <= c.pc_word;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cycle_cfg = c;
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	// Scoreboard: queue predictions on input transfers, compare on output transfers
	always @(posedge clk) begin
		iag_out_t e;
		if (in_valid && !in_stall)
			expected_ea.push_back(row_typed ? row_ea : calc_effective_address(in_data, cycle_cfg));
		if (out_valid && !out_stall) begin
			if (expected_ea.size() == 0) begin
				$display("%0t unexpected transfer: expected none, actual %h", $time, out_data);
				mismatch_count++;
			end else begin
				e = expected_ea.pop_front();
				check_field("address", e.address, out_data.address);
				check_field("indirect", 16'(e.indirect), 16'(out_data.indirect));
				check_field("index_select", 16'(e.index_select), 16'(out_data.index_select));
				check_field("new_index", e.new_index, out_data.new_index);
				check_field("index_write", 16'(e.index_write), 16'(out_data.index_write));
				check_field("new_w", e.new_w, out_data.new_w);
				check_field("w_write", 16'(e.w_write), 16'(out_data.w_write));
				check_field("pc_advance", 16'(e.pc_advance), 16'(out_data.pc_advance));
				check_field("cycles_added", 16'(e.cycles_added), 16'(out_data.cycles_added));
				check_field("illegal", 16'(e.illegal), 16'(out_data.illegal));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[indexed_address_generator_core] ERROR");
			$finish;
		end
	end

	// Result side: stall for a drawn number of cycles before each transfer, with no stall in fast stretches
	initial begin
		int hold;
		int taken;
		taken = 0;
		wait (arst_n);
		forever begin
			if (taken % 40 == 0)
				rx_fast = ($urandom_range(0, 3) == 0);
			hold = rx_fast ? 0 : $urandom_range(0, 17);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			taken++;
		end
	end

	// Stimulus
	initial begin
		iag_cfg_t c;
		iag_in_t  s;
		bit       fast;
		cycle_cfg = '{step_one: 4'd2, step_two: 4'd3, d_offset: 4'd4,
			word_offset: 4'd4, pc_word: 4'd5};

		// five-bit offsets at the extremes, with wrap
		add_row(mk_in(8'h00, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'h0000), 1'b1, mk_out(16'hFFFF, 1'b0, 2'd0, 16'hFFFF, 1'b0, 16'h0000, 1'b0,
			2'd0, 4'd1, 1'b0));
		add_row(mk_in(8'h6F, 16'hFFF8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF), 1'b1, mk_out(16'h0007, 1'b0, 2'd3, 16'hFFF8, 1'b0, 16'hFFFF, 1'b0,
			2'd0, 4'd1, 1'b0));
		add_row(mk_in(8'h10, 16'h0005, 8'h80, 8'h7F, 8'h80, 8'h7F, 16'h8000, 16'h7FFF,
			16'h8000), 1'b1, mk_out(16'hFFF5, 1'b0, 2'd0, 16'h0005, 1'b0, 16'h8000, 1'b0,
			2'd0, 4'd1, 1'b0));
		// auto increment / decrement, reset cycle settings
		add_row(mk_in(8'h80, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h5555, 16'h0000,
			16'h0000), 1'b1, mk_out(16'hFFFF, 1'b0, 2'd0, 16'h0000, 1'b1, 16'h5555, 1'b0,
			2'd0, 4'd2, 1'b0));
		add_row(mk_in(8'hA1, 16'hFFFE, 8'h01, 8'h02, 8'h03, 8'h04, 16'h0000, 16'h0000,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'hC2, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 16'hAAAA, 16'h0000,
			16'h0000), 1'b1, mk_out(16'hFFFF, 1'b0, 2'd2, 16'hFFFF, 1'b1, 16'hAAAA, 1'b0,
			2'd0, 4'd2, 1'b0));
		add_row(mk_in(8'hE3, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'h0000), 1'b0, '0);
		// register and constant offsets
		add_row(mk_in(8'h84, 16'h8000, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'h85, 16'h0010, 8'h00, 8'h80, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'hA6, 16'hFFF0, 8'h7F, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'hC7, 16'h0000, 8'h00, 8'h00, 8'hFF, 8'h00, 16'h0000, 16'h0000,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'hE8, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'h80FF), 1'b0, '0);
		add_row(mk_in(8'h89, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'hFFFF), 1'b0, '0);
		add_row(mk_in(8'h8A, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h80, 16'h0000, 16'h0000,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'h8B, 16'h0001, 8'hFF, 8'hFF, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'h8C, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'hFFFE,
			16'h7F00), 1'b0, '0);
		add_row(mk_in(8'hAD, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'hFFFF,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'h8E, 16'h0002, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF, 16'h0000,
			16'h0000), 1'b0, '0);
		// W modes in each register slot
		add_row(mk_in(8'h8F, 16'h4444, 8'h00, 8'h00, 8'h00, 8'h00, 16'h1234, 16'h0000,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'hAF, 16'h4444, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF, 16'h0000,
			16'h0002), 1'b0, '0);
		add_row(mk_in(8'hCF, 16'h4444, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFE, 16'h0000,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'hF0, 16'h4444, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0001, 16'h0000,
			16'h0000), 1'b0, '0);
		// indirect forms
		add_row(mk_in(8'hB1, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'hD3, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'h0000), 1'b0, '0);
		add_row(mk_in(8'hF2, 16'h1234, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h4321, 16'hFFFF,
			16'hFFFF), 1'b1, mk_out(16'h0000, 1'b0, 2'd3, 16'h1234, 1'b0, 16'h4321, 1'b0,
			2'd0, 4'd6, 1'b1));
		add_row(mk_in(8'hFF, 16'h1111, 8'h00, 8'h00, 8'h00, 8'h00, 16'h2222, 16'h0000,
			16'hBEEF), 1'b1, mk_out(16'hBEEF, 1'b1, 2'd3, 16'h1111, 1'b0, 16'h2222, 1'b0,
			2'd2, 4'd8, 1'b0));
		add_row(mk_in(8'h9D, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h8000,
			16'h8000), 1'b0, '0);
		add_row(mk_in(8'h94, 16'hABCD, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'h0000), 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_stim[i])
			send_item(dir_stim[i], dir_typed[i], dir_ea[i], 1'b0);

		// random phases, each under its own cycle settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			case (p)
				0:       c = '0;
				1:       c = '1;
				default: c = iag_cfg_t'(20'($urandom));
			endcase
			write_config(c);
			fast = 1'b0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 40 == 0)
					fast = ($urandom_range(0, 3) == 0);
				if (p == 2 && i == PHASE_ITEMS / 2)
					wait_drained();
				s = mk_in(8'($urandom_range(0, 255)), rand_word(), rand_byte(), rand_byte(),
					rand_byte(), rand_byte(), rand_word(), rand_word(), rand_word());
				send_item(s, 1'b0, '0, fast);
			end
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("[indexed_address_generator_core] OK");
		else
			$display("[indexed_address_generator_core] ERROR");
		$finish;
	end

endmodule
